// File: hw/rtl/mhp_pkg.sv
// Shared types, codes and helpers for the message header parser.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package mhp_pkg;

    // Header layout and fixed payload sizes
    localparam int unsigned HDR_BYTES       = 5;
    localparam logic [2:0]  HDR_VER_HI      = 3'd0;
    localparam logic [2:0]  HDR_VER_LO      = 3'd1;
    localparam logic [2:0]  HDR_TYPE        = 3'd2;
    localparam logic [2:0]  HDR_LEN_HI      = 3'd3;
    localparam logic [2:0]  HDR_LEN_LO      = 3'd4;
    localparam logic [2:0]  HDR_DONE        = 3'd5;

    localparam logic [15:0] HELLO_REQ_LEN   = 16'd64;
    localparam logic [15:0] HELLO_RSP_LEN   = 16'd16 + 16'd96;
    localparam logic [15:0] ENC_DATA_MIN    = 16'd32;
    localparam logic [15:0] MAC_BYTES       = 16'd16;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_EXPECTED_VERSION    = 3'd0,
        REG_TYPE_COUNT          = 3'd1,
        REG_MAX_PAYLOAD         = 3'd2,
        REG_HELLO_REQUEST_CODE  = 3'd3,
        REG_HELLO_RESPONSE_CODE = 3'd4,
        REG_ENCRYPTED_DATA_CODE = 3'd5
    } reg_index_t;

    // Configuration reset values
    localparam logic [15:0] RST_EXPECTED_VERSION    = 16'd1;
    localparam logic [7:0]  RST_TYPE_COUNT          = 8'd3;
    localparam logic [15:0] RST_MAX_PAYLOAD         = 16'd4096;
    localparam logic [7:0]  RST_HELLO_REQUEST_CODE  = 8'd0;
    localparam logic [7:0]  RST_HELLO_RESPONSE_CODE = 8'd1;
    localparam logic [7:0]  RST_ENCRYPTED_DATA_CODE = 8'd2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT_HDR   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_BAD_TYPE    = 3'd3,
        ST_INCOMPLETE  = 3'd4,
        ST_TOO_LONG    = 3'd5,
        ST_BAD_LENGTH  = 3'd6,
        ST_IN_PROGRESS = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        SEC_OTHER      = 3'd0,
        SEC_PUBLIC_KEY = 3'd1,
        SEC_MAC        = 3'd2,
        SEC_ENC_KEY    = 3'd3,
        SEC_DATA       = 3'd4
    } section_t;

    typedef struct packed {
        logic [15:0] expected_version;
        logic [7:0]  type_count;
        logic [15:0] max_payload;
        logic [7:0]  hello_request_code;
        logic [7:0]  hello_response_code;
        logic [7:0]  encrypted_data_code;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  msg_type;
        logic [15:0] body_len;
        logic [16:0] bytes_needed;
        logic [16:0] message_bytes;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        section_t    section;
        logic [15:0] payload_offset;
        logic        last;
    } result_t;

    // Final verdict on a complete message; hello request wins over response,
    // response over encrypted data when codes coincide
    function automatic status_t final_status(input logic [15:0] len,
                                             input logic [7:0]  typ,
                                             input cfg_t        cfg);
        status_t st;
        st = ST_OK;
        if (len > cfg.max_payload) begin
            st = ST_TOO_LONG;
        end else if (typ == cfg.hello_request_code) begin
            st = (len != HELLO_REQ_LEN) ? ST_BAD_LENGTH : ST_OK;
        end else if (typ == cfg.hello_response_code) begin
            st = (len != HELLO_RSP_LEN) ? ST_BAD_LENGTH : ST_OK;
        end else if (typ == cfg.encrypted_data_code) begin
            st = (len < ENC_DATA_MIN) ? ST_BAD_LENGTH : ST_OK;
        end
        return st;
    endfunction

    // Section tag of a payload byte by its offset
    function automatic section_t section_of(input logic [15:0] off,
                                            input logic [7:0]  typ,
                                            input cfg_t        cfg);
        section_t sec;
        sec = SEC_OTHER;
        if (typ == cfg.hello_request_code) begin
            sec = SEC_PUBLIC_KEY;
        end else if (typ == cfg.hello_response_code) begin
            sec = (off < MAC_BYTES) ? SEC_MAC : SEC_ENC_KEY;
        end else if (typ == cfg.encrypted_data_code) begin
            sec = (off < MAC_BYTES) ? SEC_MAC : SEC_DATA;
        end
        return sec;
    endfunction

endpackage

// File: hw/rtl/message_header_parser.sv
// Message header parser top level: one byte per cycle, results through a
// two-entry output buffer. Each result is registered into that buffer
// when its byte is accepted. Throughput: one byte every cycle while m_ready is high;
// a single comparison step per byte bounds the rate. Synchronous active-low
// reset clears parse state, empties the buffer and loads register defaults.
`timescale 1ns / 1ps

module message_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // Byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_buffer_end,
    // Result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_msg_type,
    output logic [15:0] m_body_len,
    output logic [16:0] m_bytes_needed,
    output logic [16:0] m_message_bytes,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_valid,
    output logic [2:0]  m_section,
    output logic [15:0] m_payload_offset,
    output logic        m_last
);
    import mhp_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t head;
    logic    res_push;
    logic    accept;

    assign accept = s_valid && s_ready;

    mhp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mhp_parse_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .accept     (accept),
        .data_byte  (s_data_byte),
        .buffer_end (s_buffer_end),
        .res_push   (res_push),
        .res        (res)
    );

    mhp_out_buffer u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .can_push  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head      (head)
    );

    // Unpack the head result onto the ports
    assign m_status         = head.status;
    assign m_msg_type       = head.msg_type;
    assign m_body_len       = head.body_len;
    assign m_bytes_needed   = head.bytes_needed;
    assign m_message_bytes  = head.message_bytes;
    assign m_payload_byte   = head.payload_byte;
    assign m_payload_valid  = head.payload_valid;
    assign m_section        = head.section;
    assign m_payload_offset = head.payload_offset;
    assign m_last           = head.last;

endmodule

// File: hw/rtl/mhp_cfg_regs.sv
// Configuration register bank of the message header parser.
// Depends on mhp_pkg for the register indexes and reset values.
`timescale 1ns / 1ps

module mhp_cfg_regs (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_addr,
    input  logic [15:0]    cfg_wdata,
    output mhp_pkg::cfg_t  cfg
);
    import mhp_pkg::*;

    cfg_t cfg_reg;

    // Write one register per enabled cycle; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_version    <= RST_EXPECTED_VERSION;
            cfg_reg.type_count          <= RST_TYPE_COUNT;
            cfg_reg.max_payload         <= RST_MAX_PAYLOAD;
            cfg_reg.hello_request_code  <= RST_HELLO_REQUEST_CODE;
            cfg_reg.hello_response_code <= RST_HELLO_RESPONSE_CODE;
            cfg_reg.encrypted_data_code <= RST_ENCRYPTED_DATA_CODE;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_EXPECTED_VERSION:    cfg_reg.expected_version    <= cfg_wdata;
                REG_TYPE_COUNT:          cfg_reg.type_count          <= cfg_wdata[7:0];
                REG_MAX_PAYLOAD:         cfg_reg.max_payload         <= cfg_wdata;
                REG_HELLO_REQUEST_CODE:  cfg_reg.hello_request_code  <= cfg_wdata[7:0];
                REG_HELLO_RESPONSE_CODE: cfg_reg.hello_response_code <= cfg_wdata[7:0];
                REG_ENCRYPTED_DATA_CODE: cfg_reg.encrypted_data_code <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/mhp_parse_core.sv
// Per-byte parse step: header/payload state and result formation.
// Depends on mhp_pkg for the status and section codes and check functions.
`timescale 1ns / 1ps

module mhp_parse_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  mhp_pkg::cfg_t     cfg,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              buffer_end,
    output logic              res_push,
    output mhp_pkg::result_t  res
);
    import mhp_pkg::*;

    logic [2:0]  header_index_reg, header_index_next;
    logic        version_ok_reg,   version_ok_next;
    logic [7:0]  type_held_reg,    type_held_next;
    logic [15:0] length_held_reg,  length_held_next;
    logic [15:0] payload_count_reg, payload_count_next;
    logic        discarding_reg,   discarding_next;

    logic        res_valid;
    result_t     res_c;
    status_t     st;
    logic        good;
    logic [15:0] pc_inc;

    // Parse one byte against the held state
    always_comb begin
        header_index_next  = header_index_reg;
        version_ok_next    = version_ok_reg;
        type_held_next     = type_held_reg;
        length_held_next   = length_held_reg;
        payload_count_next = payload_count_reg;
        discarding_next    = discarding_reg;
        res_valid          = 1'b0;
        res_c              = '0;
        st                 = ST_OK;
        good               = 1'b0;
        pc_inc             = payload_count_reg + 16'd1;

        if (discarding_reg) begin
            // Drop bytes until the buffer ends
            if (buffer_end) begin
                discarding_next   = 1'b0;
                header_index_next = HDR_VER_HI;
            end
        end else if (header_index_reg != HDR_DONE) begin
            // Collect header fields
            case (header_index_reg)
                HDR_VER_HI: version_ok_next =
                    (data_byte == cfg.expected_version[15:8]);
                HDR_VER_LO: if (data_byte != cfg.expected_version[7:0]) begin
                    version_ok_next = 1'b0;
                end
                HDR_TYPE:   type_held_next = data_byte;
                HDR_LEN_HI: length_held_next = {data_byte, 8'd0};
                default:    length_held_next = {length_held_reg[15:8], data_byte};
            endcase

            if (header_index_reg != HDR_LEN_LO) begin
                header_index_next = header_index_reg + 3'd1;
                if (buffer_end) begin
                    res_valid         = 1'b1;
                    res_c.status      = ST_SHORT_HDR;
                    res_c.last        = 1'b1;
                    header_index_next = HDR_VER_HI;
                end
            end else begin
                header_index_next  = HDR_DONE;
                payload_count_next = '0;
                res_c.msg_type     = type_held_reg;
                res_c.body_len     = length_held_next;
                priority if (!version_ok_next) begin
                    st        = ST_BAD_VERSION;
                    res_valid = 1'b1;
                end else if (type_held_reg >= cfg.type_count) begin
                    st        = ST_BAD_TYPE;
                    res_valid = 1'b1;
                end else if (length_held_next == 16'd0) begin
                    st        = final_status(length_held_next, type_held_reg, cfg);
                    res_valid = 1'b1;
                end else if (buffer_end) begin
                    res_valid          = 1'b1;
                    res_c.status       = ST_INCOMPLETE;
                    res_c.bytes_needed = {1'b0, length_held_next};
                    res_c.last         = 1'b1;
                    header_index_next  = HDR_VER_HI;
                end else begin
                    // Payload follows; no result yet
                    res_valid = 1'b0;
                end
                // Close out the message on a header-only verdict
                if (res_valid && !(buffer_end && length_held_next != 16'd0
                        && version_ok_next && type_held_reg < cfg.type_count)) begin
                    res_c.status = st;
                    if (st == ST_OK) begin
                        res_c.message_bytes = {1'b0, length_held_next} + 17'(HDR_BYTES);
                    end
                    res_c.last        = 1'b1;
                    header_index_next = HDR_VER_HI;
                    discarding_next   = (st != ST_OK) && !buffer_end;
                end
            end
        end else begin
            // Payload byte
            payload_count_next = pc_inc;
            st   = final_status(length_held_reg, type_held_reg, cfg);
            good = (st == ST_OK);
            res_c.msg_type = type_held_reg;
            res_c.body_len = length_held_reg;
            if (good) begin
                res_c.payload_byte   = data_byte;
                res_c.payload_valid  = 1'b1;
                res_c.section        = section_of(payload_count_reg, type_held_reg, cfg);
                res_c.payload_offset = payload_count_reg;
            end
            priority if (pc_inc >= length_held_reg || pc_inc == 16'd0) begin
                res_valid    = 1'b1;
                res_c.status = st;
                if (good) begin
                    res_c.message_bytes = {1'b0, length_held_reg} + 17'(HDR_BYTES);
                end
                res_c.last        = 1'b1;
                header_index_next = HDR_VER_HI;
                discarding_next   = !good && !buffer_end;
            end else if (buffer_end) begin
                res_valid          = 1'b1;
                res_c.status       = ST_INCOMPLETE;
                res_c.bytes_needed = {1'b0, length_held_reg - pc_inc};
                res_c.last         = 1'b1;
                header_index_next  = HDR_VER_HI;
            end else if (good) begin
                res_valid    = 1'b1;
                res_c.status = ST_IN_PROGRESS;
            end else begin
                // Drop a byte of a message that will be rejected
                res_valid = 1'b0;
            end
        end
    end

    // Advance state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_index_reg  <= HDR_VER_HI;
            version_ok_reg    <= 1'b0;
            type_held_reg     <= '0;
            length_held_reg   <= '0;
            payload_count_reg <= '0;
            discarding_reg    <= 1'b0;
        end else if (accept) begin
            header_index_reg  <= header_index_next;
            version_ok_reg    <= version_ok_next;
            type_held_reg     <= type_held_next;
            length_held_reg   <= length_held_next;
            payload_count_reg <= payload_count_next;
            discarding_reg    <= discarding_next;
        end
    end

    assign res_push = accept && res_valid;
    assign res      = res_c;

endmodule

// File: hw/rtl/mhp_out_buffer.sv
// Two-entry result buffer that parts the parse step from the result channel.
// Depends on mhp_pkg for the result record type.
`timescale 1ns / 1ps

module mhp_out_buffer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mhp_pkg::result_t  push_data,
    output logic              can_push,
    output logic              m_valid,
    input  logic              m_ready,
    output mhp_pkg::result_t  head
);
    import mhp_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;

    assign pop      = m_valid && m_ready;
    assign can_push = (count_reg != 2'd2);
    assign m_valid  = (count_reg != 2'd0);
    assign head     = slot0_reg;

    // Shift the queue toward the head slot
    always_comb begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop) begin
            slot0_next = slot1_reg;
        end
        if (push) begin
            if ((count_reg == 2'd0) || (count_reg == 2'd1 && pop)) begin
                slot0_next = push_data;
            end else begin
                slot1_next = push_data;
            end
        end
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // Hold count and payload slots
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule
